// File: rtl/core/sfn_pkg.sv
// Shared types and constants for the NED specific-force pipeline.
// Used by sfn_flow and specific_force_ned_from_increments_core; no dependencies.

package sfn_pkg;

   // Pipeline depth and stage positions
   localparam int NUM_STAGES = 6;
   localparam int ST_CROSS   = 0;  // cross-product partial terms
   localparam int ST_CORR    = 1;  // rotation-corrected velocity increment
   localparam int ST_TERM    = 2;  // row element times corrected increment
   localparam int ST_PROJ    = 3;  // projection onto the NED axis
   localparam int ST_SCALE   = 4;  // partial products with the reciprocal interval
   localparam int ST_OUT     = 5;  // saturated result, output register

   localparam int IN_W    = 32;
   localparam int PROD_W  = 2 * IN_W;        // 64
   localparam int HALF_W  = PROD_W + 1 - 31; // 34
   localparam int CORR_W  = 35;
   localparam int TERM_W  = IN_W + CORR_W;   // 67
   localparam int SUM_W   = TERM_W + 2;      // 69
   localparam int PROJ_W  = SUM_W - 30;      // 39
   localparam int PART_W  = PROJ_W + 17;     // 56
   localparam int FULL_W  = PART_W + 1;      // 57
   localparam int FORCE_W = 48;

   localparam logic [31:0] INV_RESET = 32'd6553600;
   localparam logic [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
   localparam logic [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;   // stage register captures this cycle
      logic [NUM_STAGES-1:0] valid;  // stage register holds an item
   } flow_type;

endpackage

// File: rtl/core/sfn_flow.sv
// Valid/ready control for the six-stage force pipeline.
// Depends on sfn_pkg for the stage count and the flow_type struct.

module sfn_flow
   import sfn_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  logic     out_ready,
   output logic     in_ready,
   output flow_type flow
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] ready;
   logic [NUM_STAGES-1:0] upstream;

   always_comb begin
      // a stage may take a new item when empty or when its own item moves on
      ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      upstream[0] = in_valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
         upstream[i] = valid_ff[i-1];
      end
      for (int i = 0; i < NUM_STAGES; i++) begin
         valid_in[i]  = ready[i] ? upstream[i] : valid_ff[i];
         flow.load[i] = ready[i] && upstream[i];
      end
      flow.valid = valid_ff;
      in_ready   = ready[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// File: rtl/core/specific_force_ned_from_increments_core.sv
// Top level of the NED specific-force block: datapath stages and config register.
// Depends on sfn_pkg and sfn_flow.

// Each item carries one DCM row plus the delta-theta and delta-velocity of a
// sample and yields one saturated specific-force component on that row's NED
// axis; three items (rows 0, 1, 2) make a full vector. The block takes one
// item per clock while the result side does not stall. It is a six-stage
// pipeline: cross products, rotation correction, row products, projection
// sum, two partial products with the reciprocal sample interval, and
// saturation into the output register. Stalls on the result side back up
// through the stages, and empty stages keep taking items. The reciprocal
// interval register (Q16.16, reset 100 Hz) may be written only while no
// item is in flight.

module specific_force_ned_from_increments_core
   import sfn_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request: tdata = dcm_row_x, dcm_row_y, dcm_row_z, angle_inc_x, angle_inc_y,
   //          angle_inc_z, vel_inc_x, vel_inc_y, vel_inc_z (32 bits each)
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [287:0] req_tdata,
   input  logic [1:0]   req_tuser,  // row_index
   // response: tdata = force_component (48 bits)
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,
   output logic [2:0]   rsp_tuser,  // axis_index [1:0], overflow [2]
   // reciprocal sample interval
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);

   flow_type flow;

   sfn_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .out_ready (rsp_tready),
      .in_ready  (req_tready),
      .flow      (flow)
   );

   // configuration register
   logic [31:0] inv_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= INV_RESET;
      end else if (csr_valid && csr_ready) begin
         inv_ff <= csr_data;
      end
   end

   // unpack request item
   logic signed [IN_W-1:0] row_w [3];
   logic signed [IN_W-1:0] dth_w [3];
   logic signed [IN_W-1:0] dv_w  [3];

   for (genvar k = 0; k < 3; k++) begin : g_unpack
      assign row_w[k] = req_tdata[IN_W*k +: IN_W];
      assign dth_w[k] = req_tdata[IN_W*(k+3) +: IN_W];
      assign dv_w[k]  = req_tdata[IN_W*(k+6) +: IN_W];
   end

   // stage: cross-product terms
   logic signed [PROD_W-1:0] pos_in [3];
   logic signed [PROD_W-1:0] neg_in [3];
   logic signed [PROD_W-1:0] pos_ff [3];
   logic signed [PROD_W-1:0] neg_ff [3];
   logic signed [IN_W-1:0]   row0_ff [3];
   logic signed [IN_W-1:0]   dv0_ff  [3];
   logic [1:0]               axis0_ff;

   always_comb begin
      pos_in[0] = dth_w[1] * dv_w[2];
      neg_in[0] = dv_w[1] * dth_w[2];
      pos_in[1] = dth_w[2] * dv_w[0];
      neg_in[1] = dv_w[2] * dth_w[0];
      pos_in[2] = dth_w[0] * dv_w[1];
      neg_in[2] = dv_w[0] * dth_w[1];
   end

   always_ff @(posedge clock) begin
      if (flow.load[ST_CROSS]) begin
         pos_ff   <= pos_in;
         neg_ff   <= neg_in;
         row0_ff  <= row_w;
         dv0_ff   <= dv_w;
         axis0_ff <= req_tuser;
      end
   end

   // stage: dv + half cross product, the shift by 31 folds in the factor 0.5
   logic signed [PROD_W:0]   diff_w [3];
   logic signed [HALF_W-1:0] half_w [3];
   logic signed [CORR_W-1:0] corr_in [3];
   logic signed [CORR_W-1:0] corr_ff [3];
   logic signed [IN_W-1:0]   row1_ff [3];
   logic [1:0]               axis1_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff_w[k]  = $signed({pos_ff[k][PROD_W-1], pos_ff[k]})
                    - $signed({neg_ff[k][PROD_W-1], neg_ff[k]});
         half_w[k]  = diff_w[k][PROD_W:31];
         corr_in[k] = $signed({{(CORR_W-IN_W){dv0_ff[k][IN_W-1]}}, dv0_ff[k]})
                    + $signed({half_w[k][HALF_W-1], half_w[k]});
      end
   end

   always_ff @(posedge clock) begin
      if (flow.load[ST_CORR]) begin
         corr_ff  <= corr_in;
         row1_ff  <= row0_ff;
         axis1_ff <= axis0_ff;
      end
   end

   // stage: row element times corrected increment
   logic signed [TERM_W-1:0] term_in [3];
   logic signed [TERM_W-1:0] term_ff [3];
   logic [1:0]               axis2_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         term_in[k] = row1_ff[k] * corr_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (flow.load[ST_TERM]) begin
         term_ff  <= term_in;
         axis2_ff <= axis1_ff;
      end
   end

   // stage: projection, drop the Q1.30 scale
   logic signed [SUM_W-1:0]  sum_w;
   logic signed [PROJ_W-1:0] proj_ff;
   logic [1:0]               axis3_ff;

   always_comb begin
      sum_w = $signed({{2{term_ff[0][TERM_W-1]}}, term_ff[0]})
            + $signed({{2{term_ff[1][TERM_W-1]}}, term_ff[1]})
            + $signed({{2{term_ff[2][TERM_W-1]}}, term_ff[2]});
   end

   always_ff @(posedge clock) begin
      if (flow.load[ST_PROJ]) begin
         proj_ff  <= sum_w[SUM_W-1:30];
         axis3_ff <= axis2_ff;
      end
   end

   // stage: split the reciprocal into 16-bit halves
   logic signed [PART_W-1:0] part_lo_in;
   logic signed [PART_W-1:0] part_hi_in;
   logic signed [PART_W-1:0] part_lo_ff;
   logic signed [PART_W-1:0] part_hi_ff;
   logic [1:0]               axis4_ff;

   always_comb begin
      part_lo_in = proj_ff * $signed({1'b0, inv_ff[15:0]});
      part_hi_in = proj_ff * $signed({1'b0, inv_ff[31:16]});
   end

   always_ff @(posedge clock) begin
      if (flow.load[ST_SCALE]) begin
         part_lo_ff <= part_lo_in;
         part_hi_ff <= part_hi_in;
         axis4_ff   <= axis3_ff;
      end
   end

   // stage: high part is already at the output scale, floor the low part
   logic signed [FULL_W-1:0] full_w;
   logic                     ovf_w;
   logic [FORCE_W-1:0]       force_w;
   logic [FORCE_W-1:0]       force_ff;
   logic                     ovf_ff;
   logic [1:0]               axis5_ff;

   always_comb begin
      full_w  = $signed({part_hi_ff[PART_W-1], part_hi_ff})
              + $signed({{17{part_lo_ff[PART_W-1]}}, part_lo_ff[PART_W-1:16]});
      ovf_w   = !((&full_w[FULL_W-1:FORCE_W-1]) || !(|full_w[FULL_W-1:FORCE_W-1]));
      force_w = full_w[FORCE_W-1:0];
      if (ovf_w) begin
         force_w = full_w[FULL_W-1] ? FORCE_MIN : FORCE_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (flow.load[ST_OUT]) begin
         force_ff <= force_w;
         ovf_ff   <= ovf_w;
         axis5_ff <= axis4_ff;
      end
   end

   assign rsp_tvalid = flow.valid[ST_OUT];
   assign rsp_tdata  = force_ff;
   assign rsp_tuser  = {ovf_ff, axis5_ff};

   // checks
   a_ovf_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tdata == FORCE_MAX || rsp_tdata == FORCE_MIN)
      else $error("overflow flagged on an unclamped force");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input held off without a stalled result");

   a_zero_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && inv_ff == '0 |-> rsp_tdata == '0 && !rsp_tuser[2])
      else $error("zero reciprocal interval gave a nonzero force");

endmodule
